// ===== hw/rtl/tmpce_pkg.sv =====
// ----------------------------------------------------------------------------
// tmpce_pkg: shared types and constants of the triangle maximum path engine
// word layouts of both channels, register indexes, command and phase codes
// ----------------------------------------------------------------------------
`default_nettype none

package tmpce_pkg;

	localparam int CNT_W = 31;
	localparam logic [CNT_W-1:0] SAT_COUNT = 31'd2000000001;

	// configuration register indexes
	localparam logic [1:0] REG_MODE       = 2'd0;
	localparam logic [1:0] REG_ROW_COUNT  = 2'd1;
	localparam logic [1:0] REG_FIRST_PATH = 2'd2;
	localparam logic [1:0] REG_LAST_PATH  = 2'd3;

	// commands
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	// modes
	localparam logic MODE_COUNT = 1'b0;
	localparam logic MODE_LIST  = 1'b1;

	// listing phases
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_ACTIVE = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	typedef struct packed {
		logic        command;
		logic [15:0] element_value;
	} in_word_t;

	typedef struct packed {
		logic [CNT_W-1:0] path_count;
		logic [8:0]       column;
		logic             path_end;
		logic             done_res;
	} out_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/triangle_max_path_count_enumerate_core.sv =====
// ----------------------------------------------------------------------------
// triangle_max_path_count_enumerate_core: maximum path triangle engine
// loads a number triangle, counts its maximum sum paths and lists them
// operation: each load writes one element; the last load starts a bottom-up sweep
//   with a row prefetch per row and a right child read, an own element read and a
//   write back per non-leaf cell, set by the single read port of the sum memory,
//   with input ready low throughout
// count fetch: result in the cycle after acceptance; list fetch: columns come from
//   the column stack, after a walk down the rows and a scan up between paths
// reset: control and config registers only; memories not cleared, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_max_path_count_enumerate_core #(
	parameter int MAX_ROWS   = 256,
	parameter int VALUE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tmpce_pkg::in_word_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tmpce_pkg::out_word_t out_data,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [30:0]          cfg_wdata
);

	import tmpce_pkg::*;

	// element bits kept, sum width, cell count and index widths
	localparam int VB_USE = (VALUE_BITS < 16) ? VALUE_BITS : 16;
	localparam int SW     = VB_USE + $clog2(MAX_ROWS);
	localparam int CELLS  = MAX_ROWS * (MAX_ROWS + 1) / 2;
	localparam int AW     = $clog2(CELLS);
	localparam int CW     = $clog2(CELLS + 1);
	localparam int RW     = $clog2(MAX_ROWS);
	localparam int NW     = $clog2(MAX_ROWS + 1);
	localparam int PW     = 2 * NW + 2;

	// sequencer states
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SW_PRE = 4'd1;   // sweep: fetch left child of row start
	localparam logic [3:0] ST_SW_RC  = 4'd2;   // sweep: fetch right child
	localparam logic [3:0] ST_SW_RO  = 4'd3;   // sweep: fetch own element
	localparam logic [3:0] ST_SW_WR  = 4'd4;   // sweep: combine and write back
	localparam logic [3:0] ST_D0     = 4'd5;   // descend: push column, fetch left
	localparam logic [3:0] ST_D1     = 4'd6;   // descend: fetch right
	localparam logic [3:0] ST_D2     = 4'd7;   // descend: choose branch
	localparam logic [3:0] ST_E0     = 4'd8;   // emit: read column stack
	localparam logic [3:0] ST_E1     = 4'd9;   // emit: form result
	localparam logic [3:0] ST_N_CHK  = 4'd10;  // next path: test branch bit
	localparam logic [3:0] ST_N_C    = 4'd11;  // next path: column arrives
	localparam logic [3:0] ST_N_L    = 4'd12;  // next path: left sum arrives
	localparam logic [3:0] ST_N_R    = 4'd13;  // next path: right sum arrives

	// configuration registers
	logic              mode_q;
	logic [8:0]        row_count_q;
	logic [30:0]       first_q;
	logic [30:0]       last_q;

	// control state
	logic [3:0]        state_q;
	logic [CW-1:0]     pos_q;
	logic              tri_ready_q;
	logic [NW-1:0]     tri_rows_q;
	logic [1:0]        phase_q;
	logic [31:0]       passed_q;
	logic [RW-1:0]     emit_q;
	logic [MAX_ROWS-1:0] bt_q;         // branch taken stack
	logic              ret_q;          // descend ends the fetch
	logic              out_valid_q;

	// working registers
	logic [CNT_W-1:0]  apex_q;
	logic [RW-1:0]     rw_q;
	logic [AW-1:0]     kb_q;
	logic [RW-1:0]     col_q;
	logic [RW-1:0]     r_q;
	logic [AW-1:0]     rb_q;
	logic [AW-1:0]     la_q;
	logic [SW-1:0]     ls_q;
	logic [SW-1:0]     rs_q;
	logic [CNT_W-1:0]  lc_q;
	logic [CNT_W-1:0]  rc_q;
	logic [8:0]        res_col_q;
	out_word_t         out_q;

	// memory ports
	logic              s_we;
	logic [AW-1:0]     s_waddr;
	logic [SW-1:0]     s_wdata;
	logic [AW-1:0]     s_raddr;
	logic [SW-1:0]     s_rdata;
	logic              c_we;
	logic [CNT_W-1:0]  c_wdata;
	logic [CNT_W-1:0]  c_rdata;
	logic              k_we;
	logic [RW-1:0]     k_waddr;
	logic [RW-1:0]     k_wdata;
	logic [RW-1:0]     k_raddr;
	logic [RW-1:0]     k_rdata;

	// derived values
	logic [NW-1:0]     n_rows;
	logic [PW-1:0]     prod;
	logic [CW-1:0]     total;
	logic              restart;
	logic [CW-1:0]     ld_addr;
	logic [CW-1:0]     ld_next;
	logic [AW-1:0]     sw_cb;
	logic [AW-1:0]     ch_base;
	logic [SW-1:0]     new_sum;
	logic [CNT_W-1:0]  new_cnt;
	logic [31:0]       cnt_add;
	logic [30:0]       frank;
	logic [32:0]       skip_sum;
	logic [8:0]        colv;
	logic              in_fire;

	assign in_fire   = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// row count clamped into 1..MAX_ROWS, and the cell count of that triangle
	always_comb begin
		if (row_count_q == 9'd0) begin
			n_rows = NW'(1);
		end else if ({{(NW + 10){1'b0}}, row_count_q} > (NW + 19)'(MAX_ROWS)) begin
			n_rows = NW'(MAX_ROWS);
		end else begin
			n_rows = NW'(row_count_q);
		end
	end

	assign prod    = PW'(n_rows) * (PW'(n_rows) + PW'(1));
	assign total   = CW'(prod >> 1);
	assign restart = tri_ready_q || (pos_q >= total);
	assign ld_addr = restart ? CW'(0) : pos_q;
	assign ld_next = ld_addr + CW'(1);

	// child row bases: sweep row and walk row
	assign sw_cb   = kb_q + AW'(rw_q) + AW'(1);
	assign ch_base = rb_q + AW'(r_q) + AW'(1);

	// sweep combine: own element plus the better child, counts add (saturating) on a tie
	assign cnt_add = {1'b0, lc_q} + {1'b0, rc_q};
	always_comb begin
		if (ls_q > rs_q) begin
			new_sum = s_rdata + ls_q;
			new_cnt = lc_q;
		end else if (ls_q < rs_q) begin
			new_sum = s_rdata + rs_q;
			new_cnt = rc_q;
		end else begin
			new_sum = s_rdata + ls_q;
			new_cnt = (cnt_add > {1'b0, SAT_COUNT}) ? SAT_COUNT : cnt_add[CNT_W-1:0];
		end
	end

	assign frank    = (first_q == 31'd0) ? 31'd1 : first_q;
	assign skip_sum = {1'b0, passed_q} + {2'b00, lc_q};
	assign colv     = 9'(k_rdata) + 9'd1;

	// memory address and write control
	always_comb begin
		s_we    = 1'b0;
		s_waddr = kb_q + AW'(col_q);
		s_wdata = new_sum;
		s_raddr = la_q + AW'(1);
		c_we    = 1'b0;
		c_wdata = new_cnt;
		k_we    = 1'b0;
		k_waddr = r_q;
		k_wdata = col_q;
		k_raddr = emit_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && in_data.command == CMD_LOAD) begin
					s_we    = 1'b1;
					c_we    = 1'b1;
					s_waddr = AW'(ld_addr);
					s_wdata = SW'(in_data.element_value[VB_USE-1:0]);
					c_wdata = CNT_W'(1);   // leaf count, overwritten above the bottom row
				end
			end
			ST_SW_PRE: s_raddr = sw_cb;
			ST_SW_RC:  s_raddr = sw_cb + AW'(col_q) + AW'(1);
			ST_SW_RO:  s_raddr = kb_q + AW'(col_q);
			ST_SW_WR: begin
				s_we = 1'b1;
				c_we = 1'b1;
			end
			ST_D0: begin
				k_we    = 1'b1;
				s_raddr = ch_base + AW'(col_q);
			end
			ST_N_CHK:  k_raddr = r_q;
			ST_N_C:    s_raddr = ch_base + AW'(k_rdata);
			default: begin
			end
		endcase
	end

	// best sum per cell
	tmpce_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_sum_ram (
		.clk  (clk),
		.we   (s_we),
		.waddr(s_waddr),
		.wdata(s_wdata),
		.raddr(s_raddr),
		.rdata(s_rdata)
	);

	// maximum path count per cell, same addressing as the sums
	tmpce_ram #(.WIDTH(CNT_W), .DEPTH(CELLS)) u_cnt_ram (
		.clk  (clk),
		.we   (c_we),
		.waddr(s_waddr),
		.wdata(c_wdata),
		.raddr(s_raddr),
		.rdata(c_rdata)
	);

	// column of the current path at each row
	tmpce_ram #(.WIDTH(RW), .DEPTH(MAX_ROWS)) u_col_ram (
		.clk  (clk),
		.we   (k_we),
		.waddr(k_waddr),
		.wdata(k_wdata),
		.raddr(k_raddr),
		.rdata(k_rdata)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_COUNT;
			row_count_q <= 9'd1;
			first_q     <= 31'd1;
			last_q      <= 31'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:       mode_q      <= cfg_wdata[0];
				REG_ROW_COUNT:  row_count_q <= cfg_wdata[8:0];
				REG_FIRST_PATH: first_q     <= cfg_wdata;
				REG_LAST_PATH:  last_q      <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			tri_ready_q <= 1'b0;
			tri_rows_q  <= NW'(1);
			phase_q     <= PH_IDLE;
			passed_q    <= '0;
			emit_q      <= '0;
			bt_q        <= '0;
			ret_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire && in_data.command == CMD_LOAD) begin
						pos_q <= ld_next;
						if (ld_next == total) begin
							// triangle complete: fresh listing state, then sweep (a single row needs none)
							tri_ready_q <= 1'b1;
							tri_rows_q  <= n_rows;
							phase_q     <= PH_IDLE;
							passed_q    <= '0;
							emit_q      <= '0;
							bt_q        <= '0;
							if (n_rows == NW'(1)) begin
								apex_q <= CNT_W'(1);
							end else begin
								state_q <= ST_SW_PRE;
								rw_q    <= RW'(n_rows - NW'(2));
								kb_q    <= AW'(total - (CW'(n_rows) << 1) + CW'(1));
								col_q   <= '0;
							end
						end else if (restart) begin
							tri_ready_q <= 1'b0;
						end
					end else if (in_fire) begin
						if (!tri_ready_q) begin
							out_valid_q <= 1'b1;
							out_q       <= '{path_count: '0, column: 9'd0,
								path_end: 1'b0, done_res: 1'b1};
						end else if (mode_q == MODE_COUNT) begin
							out_valid_q <= 1'b1;
							out_q       <= '{path_count: apex_q, column: 9'd0,
								path_end: 1'b0, done_res: 1'b1};
						end else if (phase_q == PH_DONE) begin
							out_valid_q <= 1'b1;
							out_q       <= '{path_count: '0, column: 9'd0,
								path_end: 1'b0, done_res: 1'b1};
						end else if (phase_q == PH_IDLE) begin
							// listing start: walk to the first path, or report done if the rank range is empty
							passed_q <= '0;
							emit_q   <= '0;
							if (last_q < frank || apex_q < frank) begin
								phase_q     <= PH_DONE;
								out_valid_q <= 1'b1;
								out_q       <= '{path_count: '0, column: 9'd0,
									path_end: 1'b0, done_res: 1'b1};
							end else begin
								phase_q <= PH_ACTIVE;
								r_q     <= '0;
								col_q   <= '0;
								rb_q    <= '0;
								ret_q   <= 1'b0;
								state_q <= ST_D0;
							end
						end else begin
							state_q <= ST_E0;
						end
					end
				end

				ST_SW_PRE: state_q <= ST_SW_RC;

				ST_SW_RC: begin
					// left child of a row start comes in from the prefetch
					if (col_q == '0) begin
						ls_q <= s_rdata;
						lc_q <= c_rdata;
					end
					state_q <= ST_SW_RO;
				end

				ST_SW_RO: begin
					rs_q    <= s_rdata;
					rc_q    <= c_rdata;
					state_q <= ST_SW_WR;
				end

				ST_SW_WR: begin
					// right child becomes the next cell's left child
					ls_q <= rs_q;
					lc_q <= rc_q;
					if (col_q == rw_q) begin
						if (rw_q == '0) begin
							apex_q  <= new_cnt;
							state_q <= ST_IDLE;
						end else begin
							kb_q    <= kb_q - AW'(rw_q);
							rw_q    <= rw_q - RW'(1);
							col_q   <= '0;
							state_q <= ST_SW_PRE;
						end
					end else begin
						col_q   <= col_q + RW'(1);
						state_q <= ST_SW_RC;
					end
				end

				ST_D0: begin
					if (NW'(r_q) + NW'(1) >= tri_rows_q) begin
						// reached the bottom row
						if (ret_q) begin
							out_valid_q <= 1'b1;
							out_q       <= '{path_count: '0, column: res_col_q,
								path_end: 1'b1, done_res: 1'b0};
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_E0;
						end
					end else begin
						la_q    <= ch_base + AW'(col_q);
						state_q <= ST_D1;
					end
				end

				ST_D1: begin
					ls_q    <= s_rdata;
					lc_q    <= c_rdata;
					state_q <= ST_D2;
				end

				ST_D2: begin
					// go right if the right sum is larger or the whole left subtree ranks below the first
					if (ls_q >= s_rdata) begin
						if (skip_sum < {2'b00, frank}) begin
							passed_q  <= skip_sum[31:0];
							bt_q[r_q] <= 1'b1;
							col_q     <= col_q + RW'(1);
						end else begin
							bt_q[r_q] <= 1'b0;
						end
					end else begin
						bt_q[r_q] <= 1'b1;
						col_q     <= col_q + RW'(1);
					end
					rb_q    <= ch_base;
					r_q     <= r_q + RW'(1);
					state_q <= ST_D0;
				end

				ST_E0: state_q <= ST_E1;

				ST_E1: begin
					if (NW'(emit_q) + NW'(1) >= tri_rows_q) begin
						// last column of a path
						emit_q   <= '0;
						passed_q <= passed_q + 32'd1;
						if ((passed_q + 32'd1) >= {1'b0, last_q}
							|| tri_rows_q == NW'(1)) begin
							phase_q     <= PH_DONE;
							out_valid_q <= 1'b1;
							out_q       <= '{path_count: '0, column: colv,
								path_end: 1'b1, done_res: 1'b1};
							state_q     <= ST_IDLE;
						end else begin
							res_col_q <= colv;
							r_q       <= r_q - RW'(1);
							rb_q      <= rb_q - AW'(r_q);
							state_q   <= ST_N_CHK;
						end
					end else begin
						emit_q      <= emit_q + RW'(1);
						out_valid_q <= 1'b1;
						out_q       <= '{path_count: '0, column: colv,
							path_end: 1'b0, done_res: 1'b0};
						state_q     <= ST_IDLE;
					end
				end

				ST_N_CHK: begin
					if (bt_q[r_q]) begin
						if (r_q == '0) begin
							phase_q     <= PH_DONE;
							out_valid_q <= 1'b1;
							out_q       <= '{path_count: '0, column: res_col_q,
								path_end: 1'b1, done_res: 1'b1};
							state_q     <= ST_IDLE;
						end else begin
							rb_q <= rb_q - AW'(r_q);
							r_q  <= r_q - RW'(1);
						end
					end else begin
						state_q <= ST_N_C;
					end
				end

				ST_N_C: begin
					col_q   <= k_rdata;
					la_q    <= ch_base + AW'(k_rdata);
					state_q <= ST_N_L;
				end

				ST_N_L: begin
					ls_q    <= s_rdata;
					state_q <= ST_N_R;
				end

				ST_N_R: begin
					if (s_rdata >= ls_q) begin
						// right branch also maximal: take it and walk down
						bt_q[r_q] <= 1'b1;
						rb_q      <= ch_base;
						r_q       <= r_q + RW'(1);
						col_q     <= col_q + RW'(1);
						ret_q     <= 1'b1;
						state_q   <= ST_D0;
					end else if (r_q == '0) begin
						phase_q     <= PH_DONE;
						out_valid_q <= 1'b1;
						out_q       <= '{path_count: '0, column: res_col_q,
							path_end: 1'b1, done_res: 1'b1};
						state_q     <= ST_IDLE;
					end else begin
						rb_q    <= rb_q - AW'(r_q);
						r_q     <= r_q - RW'(1);
						state_q <= ST_N_CHK;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a count only ever comes with no column and no path end
	a_count_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.path_count != '0 |->
			out_data.column == 9'd0 && !out_data.path_end)
		else $error("path count reported together with a column");

	// count mode fetch answers on the next cycle
	a_count_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.command == CMD_FETCH && mode_q == MODE_COUNT
			|=> out_valid)
		else $error("count fetch did not answer at once");

	// emit row stays inside the loaded triangle
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		NW'(emit_q) < tri_rows_q)
		else $error("emit row beyond triangle");

	// no input is taken while the sweep runs: ready is low after each write back below the apex row
	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SW_WR && rw_q != '0 |=> !in_ready)
		else $error("input ready during sweep");

endmodule

`default_nettype wire

// ===== hw/rtl/tmpce_ram.sv =====
// ----------------------------------------------------------------------------
// tmpce_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tmpce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the triangle maximum path engine
// loads triangles of many sizes, fetches path counts and path listings, and
// checks every result word against a cycle-free model of the engine
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import tmpce_pkg::*;

	localparam int MAXR      = 256;
	localparam int CELLS     = MAXR * (MAXR + 1) / 2;
	localparam int LIMIT     = 3000000;
	localparam int ITEM_GOAL = 1650;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;
	logic      cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_MODE;
	logic [30:0] cfg_wdata = '0;

	triangle_max_path_count_enumerate_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// register copies as the engine sees them
	logic        mode_q;
	logic [8:0]  rows_q;
	logic [30:0] first_q, last_q;

	// model state of the engine
	longint unsigned best_sum[CELLS];
	int unsigned     path_cnt[CELLS];
	int unsigned     col_stack[MAXR];
	bit              took_right[MAXR];
	int unsigned     load_pos;
	longint unsigned ranks_passed;
	int unsigned     emit_row;
	bit              tri_done;
	int unsigned     tri_rows;
	logic [1:0]      list_phase;
	bit              sweep_new;

	out_word_t result_q[$];
	int errs = 0;
	int items = 0;
	int cycles = 0;
	int burst_left = 0;

	function automatic int unsigned cell_at(int unsigned r, int unsigned c);
		return r * (r + 1) / 2 + c;
	endfunction

	function automatic int unsigned rows_used();
		if (rows_q == 0) return 1;
		if (rows_q > MAXR) return MAXR;
		return rows_q;
	endfunction

	function automatic longint unsigned first_rank();
		return (first_q == 0) ? 1 : first_q;
	endfunction

	// bottom-up best sums and saturating counts of maximum paths
	function automatic void sweep_sums(int unsigned n);
		int unsigned l, k;
		longint unsigned bl, br, s;
		for (int unsigned c = 0; c < n; c++) path_cnt[cell_at(n - 1, c)] = 1;
		for (int unsigned r = n - 1; r > 0; r--) begin
			for (int unsigned c = 0; c <= r - 1; c++) begin
				l = cell_at(r, c);
				k = cell_at(r - 1, c);
				bl = best_sum[l];
				br = best_sum[l + 1];
				if (bl > br) begin
					best_sum[k] += bl;
					path_cnt[k] = path_cnt[l];
				end else if (bl < br) begin
					best_sum[k] += br;
					path_cnt[k] = path_cnt[l + 1];
				end else begin
					s = longint'(path_cnt[l]) + path_cnt[l + 1];
					best_sum[k] += bl;
					path_cnt[k] = (s > SAT_COUNT) ? SAT_COUNT : int'(s);
				end
			end
		end
	endfunction

	// walk to a leaf, skipping whole subtrees ranked below the first rank
	function automatic void walk_down(int unsigned r0, int unsigned c0);
		int unsigned r, c, l;
		bit at_leaf;
		r = r0;
		c = c0;
		at_leaf = 0;
		while (!at_leaf) begin
			col_stack[r] = c;
			if (r + 1 >= tri_rows) begin
				at_leaf = 1;
			end else begin
				l = cell_at(r + 1, c);
				if (best_sum[l] >= best_sum[l + 1]) begin
					if (ranks_passed + path_cnt[l] < first_rank()) begin
						ranks_passed += path_cnt[l];
						took_right[r] = 1;
						c++;
					end else begin
						took_right[r] = 0;
					end
				end else begin
					took_right[r] = 1;
					c++;
				end
				r++;
			end
		end
	endfunction

	function automatic bit step_next_path();
		int unsigned c, l;
		for (int unsigned r = tri_rows - 1; r > 0; r--) begin
			c = col_stack[r - 1];
			l = cell_at(r, c);
			if (!took_right[r - 1] && best_sum[l + 1] >= best_sum[l]) begin
				took_right[r - 1] = 1;
				walk_down(r, c + 1);
				return 1;
			end
		end
		return 0;
	endfunction

	// one accepted word; returns 1 when it yields a result word
	function automatic bit engine_step(in_word_t w, output out_word_t res);
		int unsigned n, total;
		res = '0;
		res.done_res = 1'b1;
		if (w.command == CMD_LOAD) begin
			n = rows_used();
			total = n * (n + 1) / 2;
			if (tri_done || load_pos >= total) begin
				tri_done = 0;
				load_pos = 0;
			end
			best_sum[load_pos] = w.element_value;
			load_pos++;
			if (load_pos == total) begin
				sweep_sums(n);
				tri_rows = n;
				tri_done = 1;
				list_phase = PH_IDLE;
				ranks_passed = 0;
				emit_row = 0;
				sweep_new = 1;
				foreach (took_right[i]) took_right[i] = 0;
			end
			return 0;
		end
		if (tri_done && mode_q == MODE_COUNT) begin
			res.path_count = 31'(path_cnt[0]);
		end else if (tri_done) begin
			if (list_phase == PH_IDLE) begin
				ranks_passed = 0;
				emit_row = 0;
				if (longint'(last_q) < first_rank() || longint'(path_cnt[0]) < first_rank())
					list_phase = PH_DONE;
				else begin
					walk_down(0, 0);
					list_phase = PH_ACTIVE;
				end
			end
			if (list_phase == PH_ACTIVE) begin
				res.column = 9'(col_stack[emit_row] + 1);
				res.done_res = 1'b0;
				emit_row++;
				if (emit_row >= tri_rows) begin
					res.path_end = 1'b1;
					emit_row = 0;
					ranks_passed++;
					if (ranks_passed >= last_q || !step_next_path()) begin
						list_phase = PH_DONE;
						res.done_res = 1'b1;
					end
				end
			end
		end
		return 1;
	endfunction

	// result checker
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				$error("result word with nothing expected: %p", out_data);
				errs++;
			end else begin
				want = result_q.pop_front();
				if (out_data.path_count !== want.path_count) begin
					$error("path_count: expected %0d, got %0d", want.path_count,
						out_data.path_count);
					errs++;
				end
				if (out_data.column !== want.column) begin
					$error("column: expected %0d, got %0d", want.column, out_data.column);
					errs++;
				end
				if (out_data.path_end !== want.path_end) begin
					$error("path_end: expected %0d, got %0d", want.path_end,
						out_data.path_end);
					errs++;
				end
				if (out_data.done_res !== want.done_res) begin
					$error("done_res: expected %0d, got %0d", want.done_res,
						out_data.done_res);
					errs++;
				end
			end
		end
	end

	// receiver stalls: the pattern is picked anew at random from four kinds
	int stall_kind = 0;
	int stall_cnt = 0;
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 1;
		if (stall_cnt % 300 == 0) stall_kind <= $urandom_range(0, 3);
		case (stall_kind)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (stall_cnt % 4 == 0);
			default: out_ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// send one word, sender works in bursts with random gaps, sometimes none, between them
	task automatic send_word(logic cmd, logic [15:0] val);
		in_word_t w;
		out_word_t res;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		w.command = cmd;
		w.element_value = val;
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		items++;
		if (engine_step(w, res)) result_q.push_back(res);
	endtask

	// wait for all results, then for any sweep or path scan still running
	task automatic settle();
		int n;
		in_valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		n = tri_rows;
		repeat ((sweep_new ? 3 * n * (n + 1) / 2 + n : 0) + 8 * n + 40) @(posedge clk);
		sweep_new = 0;
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[30:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MODE:       mode_q = val[0];
			REG_ROW_COUNT:  rows_q = val[8:0];
			REG_FIRST_PATH: first_q = val[30:0];
			default:        last_q = val[30:0];
		endcase
	endtask

	task automatic setup(int unsigned m, int unsigned rows, int unsigned f,
		int unsigned l);
		settle();
		write_reg(REG_MODE, m);
		write_reg(REG_ROW_COUNT, rows);
		write_reg(REG_FIRST_PATH, f);
		write_reg(REG_LAST_PATH, l);
	endtask

	// style 0: tiny values full of ties, 1: full range, 2: all max
	task automatic load_triangle(int n, int style);
		logic [15:0] v;
		for (int i = 0; i < n * (n + 1) / 2; i++) begin
			case (style)
				0: v = 16'($urandom_range(0, 2));
				1: v = 16'($urandom);
				default: v = 16'hffff;
			endcase
			send_word(CMD_LOAD, v);
		end
	endtask

	task automatic fetch(int k);
		repeat (k) send_word(CMD_FETCH, 16'($urandom));
	endtask

	task automatic test_fetch_before_load();
		fetch(2);
		settle();
		write_reg(REG_MODE, MODE_LIST);
		fetch(1);
	endtask

	task automatic test_single_row();
		setup(MODE_COUNT, 1, 1, 1);
		send_word(CMD_LOAD, 16'hffff);
		fetch(1);
		send_word(CMD_LOAD, 16'h0000);
		settle();
		write_reg(REG_MODE, MODE_LIST);
		fetch(3);
	endtask

	// all-equal triangle: every path is maximal, count switch mid listing
	task automatic test_tie_listing();
		setup(MODE_LIST, 3, 1, 9);
		repeat (6) send_word(CMD_LOAD, 16'h0005);
		fetch(5);
		settle();
		write_reg(REG_MODE, MODE_COUNT);
		fetch(1);
		settle();
		write_reg(REG_MODE, MODE_LIST);
		fetch(10);
	endtask

	// row count zero taken as one, first rank zero taken as one
	task automatic test_zero_regs();
		setup(MODE_LIST, 0, 0, 1);
		send_word(CMD_LOAD, 16'h1234);
		fetch(2);
		setup(MODE_LIST, 2, 0, 2);
		load_triangle(2, 0);
		fetch(6);
	endtask

	task automatic test_empty_listing();
		setup(MODE_LIST, 3, 3, 2);
		repeat (6) send_word(CMD_LOAD, 16'h0001);
		fetch(2);
		setup(MODE_LIST, 3, 9, 20);
		repeat (6) send_word(CMD_LOAD, 16'h0001);
		fetch(2);
	endtask

	// partial triangle abandoned by a smaller row count
	task automatic test_restart_partial();
		setup(MODE_COUNT, 3, 1, 1);
		load_triangle(1, 1);
		send_word(CMD_LOAD, 16'h8000);
		settle();
		write_reg(REG_ROW_COUNT, 1);
		send_word(CMD_LOAD, 16'h7fff);
		fetch(1);
		setup(MODE_COUNT, 2, 1, 1);
		load_triangle(2, 0);
		load_triangle(2, 1);
		fetch(1);
	endtask

	// 32 rows of equal values: 2^31 maximum paths saturate the count
	task automatic test_saturation();
		setup(MODE_COUNT, 32, 2000000000, SAT_COUNT);
		load_triangle(32, 2);
		fetch(1);
		settle();
		write_reg(REG_MODE, MODE_LIST);
		fetch(2 * 32 + 2);
	endtask

	task automatic test_random();
		int n, k, paths;
		int unsigned m, f, l;
		while (items < ITEM_GOAL) begin
			n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 12);
			m = $urandom_range(0, 1);
			f = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3000)
				: $urandom_range(0, 6);
			l = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5)
				: f + $urandom_range(0, 6);
			setup(m, n, f, l);
			if ($urandom_range(0, 9) == 0) fetch($urandom_range(1, 2));
			if ($urandom_range(0, 9) == 0 && n > 1) begin
				load_triangle(1, 1);
				settle();
				write_reg(REG_ROW_COUNT, $urandom_range(1, 2));
				settle();
				write_reg(REG_ROW_COUNT, n);
			end
			load_triangle(n, ($urandom_range(0, 3) == 0) ? 1 : 0);
			paths = (l >= f) ? int'(l - f + 1) : 1;
			k = (m == MODE_COUNT) ? $urandom_range(1, 3) : paths * n + $urandom_range(0, 3);
			if (k > 60) k = 60;
			if (m == MODE_LIST && $urandom_range(0, 5) == 0) begin
				fetch(k / 2);
				settle();
				if ($urandom_range(0, 1)) begin
					write_reg(REG_MODE, MODE_COUNT);
					fetch(1);
					settle();
					write_reg(REG_MODE, MODE_LIST);
				end else begin
					write_reg(REG_LAST_PATH, $urandom_range(0, 8));
				end
				fetch(k - k / 2);
			end else begin
				fetch(k);
			end
		end
	endtask

	initial begin
		mode_q = MODE_COUNT;
		rows_q = 1;
		first_q = 1;
		last_q = 1;
		load_pos = 0;
		ranks_passed = 0;
		emit_row = 0;
		tri_done = 0;
		tri_rows = 1;
		list_phase = PH_IDLE;
		sweep_new = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fetch_before_load();
		test_single_row();
		test_tie_listing();
		test_zero_regs();
		test_empty_listing();
		test_restart_partial();
		test_saturation();
		test_random();
		settle();
		if (errs == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
